[hdl/video_aspect_fit_bounds_top_defines.svh]
// Assertion macros shared by the aspect fit modules.
`ifndef VIDEO_ASPECT_FIT_BOUNDS_TOP_DEFINES_SVH
`define VIDEO_ASPECT_FIT_BOUNDS_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define VAFB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vafb: same-cycle check failed");

// Next-cycle implication.
`define VAFB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vafb: next-cycle check failed");

`endif

[hdl/vafb_pkg.sv]
// Shared constants, codes and types of the aspect fit pipeline.
package vafb_pkg;

   // Divider geometry
   localparam int NUM_W           = 44;
   localparam int DEN_W           = 29;
   localparam int QUO_W           = 18;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

   localparam logic [12:0] MAX_PLAIN_WIDTH    = 13'd1920;
   localparam logic [12:0] MAX_PLAIN_HEIGHT   = 13'd1080;
   localparam logic [15:0] PIXEL_ASPECT_RESET = 16'd4096;
   // floor(x/3) == (x * RECIP3) >> 17 for any 16-bit x
   localparam logic [15:0] RECIP3             = 16'd43691;
   localparam logic [9:0]  TOL_SCALE          = 10'd1000;
   localparam logic [10:0] RATIO_169          = 11'd1777;
   localparam logic [4:0]  DEN_64_27          = 5'd27;
   localparam logic [4:0]  DEN_16_9           = 5'd9;
   localparam logic [4:0]  DEN_4_3            = 5'd3;

   localparam logic [2:0] MODE_NONE    = 3'd0;
   localparam logic [2:0] MODE_DIRECT  = 3'd1;
   localparam logic [2:0] MODE_NORMAL  = 3'd2;
   localparam logic [2:0] MODE_STRETCH = 3'd3;
   localparam logic [2:0] MODE_PILLAR  = 3'd4;
   localparam logic [2:0] MODE_ZOOM    = 3'd5;
   localparam logic [2:0] MODE_GLOBAL  = 3'd6;

   localparam logic REG_ZOOM_MODE    = 1'b0;
   localparam logic REG_PIXEL_ASPECT = 1'b1;

   // How the quotient is placed: pass the target, quotient is height,
   // quotient is width, or quotient is width with the zoom height.
   typedef enum logic [1:0] {
      ACT_PASS,
      ACT_H,
      ACT_W,
      ACT_Z
   } act_type;

   typedef struct packed {
      logic signed [15:0] tx;
      logic signed [15:0] ty;
      logic [13:0]        tw;
      logic [13:0]        th;
      logic [14:0]        hh;
      act_type            act;
      logic               degen;
   } side_type;

endpackage

[hdl/video_aspect_fit_bounds_top.sv]
// Top level of the aspect fit block: register file and the three pipeline sections.
//
// Places a decoded frame inside a target rectangle according to the zoom mode
// (none, direct, normal, 16:9 stretch, 4:3 pillarbox, zoom, global). One
// rectangle is accepted per clock and one placed rectangle comes out per
// clock while rsp_tready holds; between the req transaction and rsp_tvalid lie five
// front stages (content size, cross products, ratio tests, operand select),
// ten divider stages (operand check plus nine stages retiring two quotient
// bits each) and two back stages (centering, then the saturated result
// register). Each stage holds its item only while the stage behind it is full,
// so a stalled rsp side fills empty stages before req_tready drops. Quotients
// truncate toward zero, edges and sizes saturate to their fields, and a zero
// divisor in the none, direct, normal or zoom modes returns the target with
// degenerate set on rsp_tuser. Write zoom_mode (0x0) and pixel_aspect (0x4,
// Q4.12) only while no transaction is in flight.
module video_aspect_fit_bounds_top (
   input  logic        clock,
   input  logic        reset,
   // target_x[15:0], target_y[31:16], target_width[45:32], target_height[59:46],
   // source_width[72:60], source_height[85:73], zero pad[87:86]
   input  logic [87:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // placed_x[15:0], placed_y[31:16], placed_width[46:32], placed_height[61:47],
   // zero pad[63:62]
   output logic [63:0] rsp_tdata,
   // degenerate[0]
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import vafb_pkg::*;

   logic [2:0]  zoom_mode_ff;
   logic [15:0] pixel_aspect_ff;
   logic        csr_write;

   logic                f_valid, f_ready;
   logic [NUM_W-1:0]    f_num;
   logic [DEN_W-1:0]    f_den;
   side_type            f_side;
   logic                d_valid, d_ready;
   logic [QUO_W-1:0]    d_q;
   side_type            d_side;

   logic signed [15:0]  px, py;
   logic [14:0]         pw, ph;
   logic                pdegen;

   // Register file: always ready, written on the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_mode_ff    <= MODE_NONE;
         pixel_aspect_ff <= PIXEL_ASPECT_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_ZOOM_MODE) zoom_mode_ff <= csr_pwdata[2:0];
         else                               pixel_aspect_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_PIXEL_ASPECT) ? {16'b0, pixel_aspect_ff}
                                                          : {29'b0, zoom_mode_ff};

   // Products, ratio tests and selection of the one division each item needs.
   vafb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_tx        (req_tdata[15:0]),
      .in_ty        (req_tdata[31:16]),
      .in_tw        (req_tdata[45:32]),
      .in_th        (req_tdata[59:46]),
      .in_sw        (req_tdata[72:60]),
      .in_sh        (req_tdata[85:73]),
      .zoom_mode    (zoom_mode_ff),
      .pixel_aspect (pixel_aspect_ff),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_num      (f_num),
      .out_den      (f_den),
      .out_side     (f_side)
   );

   // Shared quotient for all modes, constant divisors included.
   vafb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_side   (f_side),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_q     (d_q),
      .out_side  (d_side)
   );

   // Center, clamp and hold the result for the rsp side.
   vafb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_q      (d_q),
      .in_side   (d_side),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (px),
      .out_y     (py),
      .out_w     (pw),
      .out_h     (ph),
      .out_degen (pdegen)
   );

   assign rsp_tdata = {2'b00, ph, pw, py, px};
   assign rsp_tuser = pdegen;

endmodule

[hdl/vafb_front.sv]
// Front end: content size, cross products, ratio tests and divider operand selection.
module vafb_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [15:0]           in_tx,
   input  logic signed [15:0]           in_ty,
   input  logic [13:0]                  in_tw,
   input  logic [13:0]                  in_th,
   input  logic [12:0]                  in_sw,
   input  logic [12:0]                  in_sh,
   input  logic [2:0]                   zoom_mode,
   input  logic [15:0]                  pixel_aspect,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [vafb_pkg::NUM_W-1:0]   out_num,
   output logic [vafb_pkg::DEN_W-1:0]   out_den,
   output vafb_pkg::side_type           out_side
);
   import vafb_pkg::*;

   logic r1, r2, r3, r4, r5;

   // stage 1
   logic s1_v_ff;
   side_type s1_side_ff;
   logic [2:0] s1_mode_ff, s1_mode_in;
   logic s1_zd_ff, s1_zd_in;
   logic [28:0] s1_cw_ff;
   logic [12:0] s1_sh_ff;
   logic [26:0] s1_tws_ff, s1_ths_ff;
   logic [14:0] s1_hh_ff;
   logic [31:0] hh_prod;
   side_type s1_side_in;

   // stage 2
   logic s2_v_ff;
   side_type s2_side_ff;
   logic [2:0] s2_mode_ff;
   logic s2_zd_ff;
   logic [28:0] s2_cw_ff;
   logic [12:0] s2_sh_ff;
   logic [26:0] s2_tws_ff, s2_ths_ff;
   logic [14:0] s2_hh_ff;
   logic [42:0] s2_p1_ff;
   logic [43:0] s2_pz_ff;
   logic [38:0] s2_c1000_ff;
   logic [23:0] s2_c1777_ff;

   // stage 3
   logic s3_v_ff;
   side_type s3_side_ff;
   logic [2:0] s3_mode_ff;
   logic s3_zd_ff;
   logic [28:0] s3_cw_ff;
   logic [12:0] s3_sh_ff;
   logic [26:0] s3_tws_ff, s3_ths_ff;
   logic [14:0] s3_hh_ff;
   logic [42:0] s3_p1_ff;
   logic [43:0] s3_pz_ff;
   logic s3_wide_ff, s3_wide_in;
   logic [42:0] s3_diff_ff, s3_diff_in;
   logic s3_n169_ff, s3_n169_in;
   logic [42:0] twch;
   logic [38:0] c1777ch, d169;

   // stage 4
   logic s4_v_ff;
   side_type s4_side_ff;
   logic [2:0] s4_mode_ff;
   logic s4_zd_ff;
   logic [28:0] s4_cw_ff;
   logic [12:0] s4_sh_ff;
   logic [26:0] s4_tws_ff, s4_ths_ff;
   logic [14:0] s4_hh_ff;
   logic [42:0] s4_p1_ff;
   logic [43:0] s4_pz_ff;
   logic s4_wide_ff, s4_n169_ff;
   logic [52:0] s4_d1000_ff;

   // stage 5 (output)
   logic s5_v_ff;
   logic [NUM_W-1:0] s5_num_ff, s5_num_in;
   logic [DEN_W-1:0] s5_den_ff, s5_den_in;
   side_type s5_side_ff, s5_side_in;
   logic near_eq, both169;
   logic [28:0] ch4;

   assign r5 = !s5_v_ff || out_ready;
   assign r4 = !s4_v_ff || r5;
   assign r3 = !s3_v_ff || r4;
   assign r2 = !s2_v_ff || r3;
   assign r1 = !s1_v_ff || r2;
   assign in_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         if (r1) s1_v_ff <= in_valid;
         if (r2) s2_v_ff <= s1_v_ff;
         if (r3) s3_v_ff <= s2_v_ff;
         if (r4) s4_v_ff <= s3_v_ff;
         if (r5) s5_v_ff <= s4_v_ff;
      end
   end

   // stage 1: large frames force normal mode
   always_comb begin
      if (in_sw > MAX_PLAIN_WIDTH || in_sh > MAX_PLAIN_HEIGHT) s1_mode_in = MODE_NORMAL;
      else s1_mode_in = zoom_mode;
      s1_zd_in = (in_th == '0) || (in_sh == '0) || (in_sw == '0) || (pixel_aspect == '0);
      hh_prod = 32'({in_th, 2'b00}) * 32'(RECIP3);
      s1_side_in.tx    = in_tx;
      s1_side_in.ty    = in_ty;
      s1_side_in.tw    = in_tw;
      s1_side_in.th    = in_th;
      s1_side_in.hh    = hh_prod[31:17];
      s1_side_in.act   = ACT_PASS;
      s1_side_in.degen = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         s1_side_ff <= s1_side_in;
         s1_mode_ff <= s1_mode_in;
         s1_zd_ff   <= s1_zd_in;
         s1_cw_ff   <= 29'(in_sw) * 29'(pixel_aspect);
         s1_sh_ff   <= in_sh;
         s1_tws_ff  <= 27'(in_tw) * 27'(in_sh);
         s1_ths_ff  <= 27'(in_th) * 27'(in_sh);
         s1_hh_ff   <= hh_prod[31:17];
      end
   end

   // stage 2: cross products
   always_ff @(posedge clock) begin
      if (r2) begin
         s2_side_ff  <= s1_side_ff;
         s2_mode_ff  <= s1_mode_ff;
         s2_zd_ff    <= s1_zd_ff;
         s2_cw_ff    <= s1_cw_ff;
         s2_sh_ff    <= s1_sh_ff;
         s2_tws_ff   <= s1_tws_ff;
         s2_ths_ff   <= s1_ths_ff;
         s2_hh_ff    <= s1_hh_ff;
         s2_p1_ff    <= 43'(s1_cw_ff) * 43'(s1_side_ff.th);
         s2_pz_ff    <= 44'(s1_cw_ff) * 44'(s1_hh_ff);
         s2_c1000_ff <= 39'(s1_cw_ff) * 39'(TOL_SCALE);
         s2_c1777_ff <= 24'(s1_sh_ff) * 24'(RATIO_169);
      end
   end

   // stage 3: wider-or-equal test, ratio difference, 16:9 test
   always_comb begin
      twch       = 43'({s2_tws_ff, 12'b0});
      s3_wide_in = s2_p1_ff >= twch;
      s3_diff_in = s3_wide_in ? s2_p1_ff - twch : twch - s2_p1_ff;
      c1777ch    = 39'({s2_c1777_ff, 12'b0});
      d169       = (s2_c1000_ff >= c1777ch) ? s2_c1000_ff - c1777ch : c1777ch - s2_c1000_ff;
      s3_n169_in = d169 < 39'({s2_sh_ff, 12'b0});
   end

   always_ff @(posedge clock) begin
      if (r3) begin
         s3_side_ff <= s2_side_ff;
         s3_mode_ff <= s2_mode_ff;
         s3_zd_ff   <= s2_zd_ff;
         s3_cw_ff   <= s2_cw_ff;
         s3_sh_ff   <= s2_sh_ff;
         s3_tws_ff  <= s2_tws_ff;
         s3_ths_ff  <= s2_ths_ff;
         s3_hh_ff   <= s2_hh_ff;
         s3_p1_ff   <= s2_p1_ff;
         s3_pz_ff   <= s2_pz_ff;
         s3_wide_ff <= s3_wide_in;
         s3_diff_ff <= s3_diff_in;
         s3_n169_ff <= s3_n169_in;
      end
   end

   // stage 4: scale the difference by the tolerance
   always_ff @(posedge clock) begin
      if (r4) begin
         s4_side_ff  <= s3_side_ff;
         s4_mode_ff  <= s3_mode_ff;
         s4_zd_ff    <= s3_zd_ff;
         s4_cw_ff    <= s3_cw_ff;
         s4_sh_ff    <= s3_sh_ff;
         s4_tws_ff   <= s3_tws_ff;
         s4_ths_ff   <= s3_ths_ff;
         s4_hh_ff    <= s3_hh_ff;
         s4_p1_ff    <= s3_p1_ff;
         s4_pz_ff    <= s3_pz_ff;
         s4_wide_ff  <= s3_wide_ff;
         s4_n169_ff  <= s3_n169_ff;
         s4_d1000_ff <= 53'(s3_diff_ff) * 53'(TOL_SCALE);
      end
   end

   // stage 5: pick the division for the mode
   always_comb begin
      near_eq    = s4_d1000_ff < 53'({s4_ths_ff, 12'b0});
      both169    = near_eq && s4_n169_ff;
      ch4        = 29'({s4_sh_ff, 12'b0});
      s5_side_in = s4_side_ff;
      s5_num_in  = '0;
      s5_den_in  = DEN_W'(1);
      unique case (s4_mode_ff)
         MODE_NONE, MODE_DIRECT, MODE_NORMAL: begin
            if (s4_zd_ff) begin
               s5_side_in.act   = ACT_PASS;
               s5_side_in.degen = 1'b1;
            end else if (s4_wide_ff) begin
               s5_side_in.act = ACT_H;
               s5_num_in      = NUM_W'({s4_tws_ff, 12'b0});
               s5_den_in      = s4_cw_ff;
            end else begin
               s5_side_in.act = ACT_W;
               s5_num_in      = NUM_W'(s4_p1_ff);
               s5_den_in      = ch4;
            end
         end
         MODE_STRETCH: begin
            s5_side_in.act = ACT_W;
            s5_num_in      = both169 ? NUM_W'({s4_side_ff.th, 6'b0})
                                     : NUM_W'({s4_side_ff.th, 4'b0});
            s5_den_in      = both169 ? DEN_W'(DEN_64_27) : DEN_W'(DEN_16_9);
         end
         MODE_PILLAR: begin
            s5_side_in.act = ACT_W;
            s5_num_in      = NUM_W'({s4_side_ff.th, 2'b0});
            s5_den_in      = DEN_W'(DEN_4_3);
         end
         MODE_ZOOM: begin
            if (s4_zd_ff) begin
               s5_side_in.act   = ACT_PASS;
               s5_side_in.degen = 1'b1;
            end else if (s4_wide_ff) begin
               s5_side_in.act = ACT_Z;
               s5_side_in.hh  = both169 ? s4_hh_ff : 15'(s4_side_ff.th);
               s5_num_in      = both169 ? s4_pz_ff : NUM_W'(s4_p1_ff);
               s5_den_in      = ch4;
            end else begin
               s5_side_in.act = ACT_H;
               s5_num_in      = NUM_W'({s4_tws_ff, 12'b0});
               s5_den_in      = s4_cw_ff;
            end
         end
         MODE_GLOBAL: s5_side_in.act = ACT_PASS;
         default:     s5_side_in.act = ACT_PASS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (r5) begin
         s5_side_ff <= s5_side_in;
         s5_num_ff  <= s5_num_in;
         s5_den_ff  <= s5_den_in;
      end
   end

   assign out_valid = s5_v_ff;
   assign out_num   = s5_num_ff;
   assign out_den   = s5_den_ff;
   assign out_side  = s5_side_ff;

`include "video_aspect_fit_bounds_top_defines.svh"

   `VAFB_ASSERT_NOW(a_front_degen_pass, out_valid && out_side.degen, out_side.act == ACT_PASS)

endmodule

[hdl/vafb_div.sv]
// Pipelined restoring divider with a saturating quotient.
module vafb_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [vafb_pkg::NUM_W-1:0]   in_num,
   input  logic [vafb_pkg::DEN_W-1:0]   in_den,
   input  vafb_pkg::side_type           in_side,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [vafb_pkg::QUO_W-1:0]   out_q,
   output vafb_pkg::side_type           out_side
);
   import vafb_pkg::*;

   logic             v_ff   [0:DIV_STAGES];
   logic             rdy    [0:DIV_STAGES+1];
   logic [DEN_W-1:0] rem_ff [0:DIV_STAGES];
   logic [QUO_W-1:0] low_ff [0:DIV_STAGES];
   logic [DEN_W-1:0] den_ff [0:DIV_STAGES];
   logic             ovf_ff [0:DIV_STAGES];
   side_type         side_ff[0:DIV_STAGES];
   logic [DEN_W-1:0] rem_in [1:DIV_STAGES];
   logic [QUO_W-1:0] low_in [1:DIV_STAGES];
   logic             ovf_in;

   assign rdy[DIV_STAGES+1] = out_ready;
   assign in_ready          = rdy[0];

   // quotient would not fit: saturate
   assign ovf_in = (DEN_W+QUO_W)'(in_num) >= {in_den, {QUO_W{1'b0}}};

   genvar g;
   for (g = 0; g <= DIV_STAGES; g++) begin : g_rdy
      assign rdy[g] = !v_ff[g] || rdy[g+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         rem_ff[0]  <= DEN_W'(in_num[NUM_W-1:QUO_W]);
         low_ff[0]  <= in_num[QUO_W-1:0];
         den_ff[0]  <= in_den;
         ovf_ff[0]  <= ovf_in;
         side_ff[0] <= in_side;
      end
   end

   for (g = 1; g <= DIV_STAGES; g++) begin : g_stage
      always_comb begin : step
         logic [DEN_W-1:0] r;
         logic [QUO_W-1:0] l;
         logic [DEN_W:0]   t;
         r = rem_ff[g-1];
         l = low_ff[g-1];
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            t = {r, l[QUO_W-1]};
            if (t >= {1'b0, den_ff[g-1]}) begin
               r = DEN_W'(t - {1'b0, den_ff[g-1]});
               l = {l[QUO_W-2:0], 1'b1};
            end else begin
               r = t[DEN_W-1:0];
               l = {l[QUO_W-2:0], 1'b0};
            end
         end
         rem_in[g] = r;
         low_in[g] = l;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            v_ff[g] <= v_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[g]) begin
            rem_ff[g]  <= rem_in[g];
            low_ff[g]  <= low_in[g];
            den_ff[g]  <= den_ff[g-1];
            ovf_ff[g]  <= ovf_ff[g-1];
            side_ff[g] <= side_ff[g-1];
         end
      end
   end

   assign out_valid = v_ff[DIV_STAGES];
   assign out_q     = ovf_ff[DIV_STAGES] ? {QUO_W{1'b1}} : low_ff[DIV_STAGES];
   assign out_side  = side_ff[DIV_STAGES];

`include "video_aspect_fit_bounds_top_defines.svh"

   `VAFB_ASSERT_NOW(a_div_stall_holds_first, !in_ready, v_ff[0])

endmodule

[hdl/vafb_back.sv]
// Back end: centering, saturation and the result register.
module vafb_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [vafb_pkg::QUO_W-1:0]   in_q,
   input  vafb_pkg::side_type           in_side,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [15:0]           out_x,
   output logic signed [15:0]           out_y,
   output logic [14:0]                  out_w,
   output logic [14:0]                  out_h,
   output logic                         out_degen
);
   import vafb_pkg::*;

   logic r1, r2;
   logic [QUO_W-1:0] vw, vh;
   logic signed [QUO_W:0] dx, dy, dxr, dyr;

   logic b1_v_ff;
   logic signed [15:0] b1_tx_ff, b1_ty_ff;
   logic signed [QUO_W-1:0] b1_hx_ff, b1_hy_ff;
   logic [QUO_W-1:0] b1_vw_ff, b1_vh_ff;
   logic b1_degen_ff;

   logic signed [QUO_W+1:0] sx, sy;
   logic signed [15:0] ox_in, oy_in;

   logic o_v_ff;
   logic signed [15:0] o_x_ff, o_y_ff;
   logic [14:0] o_w_ff, o_h_ff;
   logic o_degen_ff;

   assign r2       = !o_v_ff || out_ready;
   assign r1       = !b1_v_ff || r2;
   assign in_ready = r1;

   // placed size, then half the slack truncated toward zero
   always_comb begin
      unique case (in_side.act)
         ACT_PASS: begin vw = QUO_W'(in_side.tw); vh = QUO_W'(in_side.th); end
         ACT_H:    begin vw = QUO_W'(in_side.tw); vh = in_q; end
         ACT_W:    begin vw = in_q;               vh = QUO_W'(in_side.th); end
         ACT_Z:    begin vw = in_q;               vh = QUO_W'(in_side.hh); end
      endcase
      dx  = (QUO_W+1)'(in_side.tw) - (QUO_W+1)'(vw);
      dy  = (QUO_W+1)'(in_side.th) - (QUO_W+1)'(vh);
      dxr = dx + (QUO_W+1)'(dx[QUO_W]);
      dyr = dy + (QUO_W+1)'(dy[QUO_W]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else begin
         if (r1) b1_v_ff <= in_valid;
         if (r2) o_v_ff  <= b1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         b1_tx_ff    <= in_side.tx;
         b1_ty_ff    <= in_side.ty;
         b1_hx_ff    <= dxr[QUO_W:1];
         b1_hy_ff    <= dyr[QUO_W:1];
         b1_vw_ff    <= vw;
         b1_vh_ff    <= vh;
         b1_degen_ff <= in_side.degen;
      end
   end

   // edge sums and clamp to the field ranges
   always_comb begin
      sx = (QUO_W+2)'(b1_tx_ff) + (QUO_W+2)'(b1_hx_ff);
      sy = (QUO_W+2)'(b1_ty_ff) + (QUO_W+2)'(b1_hy_ff);
      if (sx > (QUO_W+2)'(32767))       ox_in = 16'sh7FFF;
      else if (sx < -(QUO_W+2)'(32768)) ox_in = 16'sh8000;
      else                              ox_in = sx[15:0];
      if (sy > (QUO_W+2)'(32767))       oy_in = 16'sh7FFF;
      else if (sy < -(QUO_W+2)'(32768)) oy_in = 16'sh8000;
      else                              oy_in = sy[15:0];
   end

   always_ff @(posedge clock) begin
      if (r2) begin
         o_x_ff     <= ox_in;
         o_y_ff     <= oy_in;
         o_w_ff     <= (b1_vw_ff > QUO_W'(32767)) ? 15'h7FFF : b1_vw_ff[14:0];
         o_h_ff     <= (b1_vh_ff > QUO_W'(32767)) ? 15'h7FFF : b1_vh_ff[14:0];
         o_degen_ff <= b1_degen_ff;
      end
   end

   assign out_valid = o_v_ff;
   assign out_x     = o_x_ff;
   assign out_y     = o_y_ff;
   assign out_w     = o_w_ff;
   assign out_h     = o_h_ff;
   assign out_degen = o_degen_ff;

`include "video_aspect_fit_bounds_top_defines.svh"

   `VAFB_ASSERT_NOW(a_back_pass_q_zero, in_valid && in_side.act == ACT_PASS, in_q == '0)
   `VAFB_ASSERT_NOW(a_back_degen_size, out_valid && out_degen, !out_w[14] && !out_h[14])

endmodule
